FILE: src/improv_serial_frame_parser_core_defines.svh
// assertion macros for the improv serial frame parser
`ifndef IMPROV_SERIAL_FRAME_PARSER_CORE_DEFINES_SVH
`define IMPROV_SERIAL_FRAME_PARSER_CORE_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define ISFP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("isfp check failed");

// next-cycle implication
`define ISFP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("isfp check failed");

`endif

FILE: src/isfp_pkg.sv
// shared types, codes and constants of the improv serial frame parser
package isfp_pkg;

	localparam int unsigned POS_W = 9;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned VERDICT_W = 3;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned OUT_DATA_W = 48;

	localparam logic [POS_W-1:0] POS_VERSION = 9'd6;
	localparam logic [POS_W-1:0] POS_TYPE = 9'd7;
	localparam logic [POS_W-1:0] POS_LENGTH = 9'd8;
	localparam logic [POS_W-1:0] POS_PAYLOAD = 9'd9;

	localparam logic [POS_W-1:0] IDX_COMMAND = 9'd0;
	localparam logic [POS_W-1:0] IDX_INNER = 9'd1;
	localparam logic [POS_W-1:0] IDX_FIRST_LEN = 9'd2;
	localparam logic [POS_W-1:0] FIRST_STR_OFS = 9'd3;

	localparam logic [VERDICT_W-1:0] V_MID = 3'd0;
	localparam logic [VERDICT_W-1:0] V_REJECT = 3'd1;
	localparam logic [VERDICT_W-1:0] V_RPC_OK = 3'd2;
	localparam logic [VERDICT_W-1:0] V_RPC_BAD = 3'd3;
	localparam logic [VERDICT_W-1:0] V_SUM_ERR = 3'd4;
	localparam logic [VERDICT_W-1:0] V_OTHER = 3'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RPC_TYPE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WIFI_CMD = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_CMD = 2'd3;

	localparam logic [BYTE_W-1:0] RST_VERSION = 8'd1;
	localparam logic [BYTE_W-1:0] RST_RPC_TYPE = 8'd3;
	localparam logic [BYTE_W-1:0] RST_WIFI_CMD = 8'd1;
	localparam logic [BYTE_W-1:0] RST_TRIGGER_CMD = 8'd2;

	typedef struct packed {
		logic [BYTE_W-1:0] version_code;
		logic [BYTE_W-1:0] rpc_type_code;
		logic [BYTE_W-1:0] wifi_command_code;
		logic [BYTE_W-1:0] trigger_command_code;
	} cfg_t;

	// one classified byte, with a snapshot of the frame state at the checksum
	typedef struct packed {
		logic              acc;
		logic [POS_W-1:0]  pos;
		logic              is_sum;
		logic [BYTE_W-1:0] kind;
		logic [BYTE_W-1:0] flen;
		logic [BYTE_W-1:0] cmd;
		logic [BYTE_W-1:0] inner;
		logic [BYTE_W-1:0] len1;
		logic [BYTE_W-1:0] len2;
		logic              have2;
	} rec_t;

	// "IMPROV"
	function automatic logic [BYTE_W-1:0] hdr_byte(input logic [2:0] idx);
		logic [BYTE_W-1:0] b;
		unique case (idx)
			3'd0: b = 8'h49;
			3'd1: b = 8'h4D;
			3'd2: b = 8'h50;
			3'd3: b = 8'h52;
			3'd4: b = 8'h4F;
			3'd5: b = 8'h56;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

FILE: src/improv_serial_frame_parser_core.sv
// top level of the improv serial frame parser
//
// s_* channel: one received serial byte per request in s_tdata[7:0].
// m_* channel: one result per input byte, with the byte's frame position,
// whether it was accepted, and at the checksum byte the frame verdict in
// m_tuser together with type, command and string lengths of the frame.
// cfg_*: registers written with cfg_we, index 0 version, 1 rpc type,
// 2 wifi command, 3 trigger command; write only while the block is idle.
// A taken byte's record passes a queue entry, then the output register.
// Throughput: one byte per cycle while s_tready is high; the front end
// checks and captures on acceptance; the back end judges on queue pop.
// A two-entry queue separates the two, so s_tready drops only when the
// queue holds two requests, i.e. after the receiver stalls m_tready.
// While m_tready is low the result on m_* holds.
// Reset clears the frame position, the running sum, the queue and the
// output valid, and loads the register defaults.
module improv_serial_frame_parser_core import isfp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [BYTE_W-1:0]     s_tdata,   // rx_byte
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // accepted, frame_position, frame_kind,
	                                         // command_code, first_length,
	                                         // second_length, has_second, zero fill
	output logic [VERDICT_W-1:0]  m_tuser,   // verdict
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [BYTE_W-1:0]     cfg_data
);

	cfg_t cfg_q;
	rec_t front_rec;
	rec_t back_rec;
	logic push;
	logic full;
	logic avail;
	logic pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.version_code <= RST_VERSION;
			cfg_q.rpc_type_code <= RST_RPC_TYPE;
			cfg_q.wifi_command_code <= RST_WIFI_CMD;
			cfg_q.trigger_command_code <= RST_TRIGGER_CMD;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_VERSION: cfg_q.version_code <= cfg_data;
				CFG_RPC_TYPE: cfg_q.rpc_type_code <= cfg_data;
				CFG_WIFI_CMD: cfg_q.wifi_command_code <= cfg_data;
				CFG_TRIGGER_CMD: cfg_q.trigger_command_code <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_tready = !full;
	assign push = s_tvalid && !full;

	isfp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.rx_byte      (s_tdata),
		.version_code (cfg_q.version_code),
		.rec          (front_rec)
	);

	isfp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (front_rec),
		.full     (full),
		.pop      (pop),
		.avail    (avail),
		.pop_rec  (back_rec)
	);

	isfp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.avail    (avail),
		.rec      (back_rec),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

FILE: src/isfp_front.sv
// front end: position tracking, header and checksum checks, payload capture
module isfp_front import isfp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic [BYTE_W-1:0] version_code,
	output rec_t              rec
);

	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] sum_q;
	logic              have2_q;
	logic [BYTE_W-1:0] kind_q;
	logic [BYTE_W-1:0] flen_q;
	logic [BYTE_W-1:0] cmd_q;
	logic [BYTE_W-1:0] inner_q;
	logic [BYTE_W-1:0] len1_q;
	logic [BYTE_W-1:0] len2_q;

	logic [POS_W-1:0] last;
	logic [POS_W-1:0] idx;
	logic             in_payload;
	logic             is_sum;
	logic             acc;
	logic             restart;

	assign last = POS_PAYLOAD + {1'b0, flen_q};
	assign idx = pos_q - POS_PAYLOAD;
	assign in_payload = (pos_q >= POS_PAYLOAD) && (pos_q < last);
	assign is_sum = (pos_q >= POS_PAYLOAD) && !(pos_q < last);

	always_comb begin
		if (pos_q < POS_VERSION) begin
			acc = (rx_byte == hdr_byte(pos_q[2:0]));
		end else if (pos_q == POS_VERSION) begin
			acc = (rx_byte == version_code);
		end else if (is_sum) begin
			acc = (rx_byte == sum_q);
		end else begin
			acc = 1'b1;
		end
	end

	assign restart = !acc || is_sum;

	always_comb begin
		rec.acc = acc;
		rec.pos = pos_q;
		rec.is_sum = is_sum;
		rec.kind = kind_q;
		rec.flen = flen_q;
		rec.cmd = cmd_q;
		rec.inner = inner_q;
		rec.len1 = len1_q;
		rec.len2 = len2_q;
		rec.have2 = have2_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= '0;
			have2_q <= 1'b0;
			kind_q <= '0;
			flen_q <= '0;
			cmd_q <= '0;
			inner_q <= '0;
			len1_q <= '0;
			len2_q <= '0;
		end else if (push) begin
			if (restart) begin
				pos_q <= '0;
				sum_q <= '0;
				have2_q <= 1'b0;
			end else begin
				pos_q <= pos_q + 9'd1;
				sum_q <= sum_q + rx_byte;
			end
			if (pos_q == POS_TYPE) begin
				kind_q <= rx_byte;
			end
			if (pos_q == POS_LENGTH) begin
				flen_q <= rx_byte;
			end
			if (in_payload) begin
				if (idx == IDX_COMMAND) begin
					cmd_q <= rx_byte;
				end else if (idx == IDX_INNER) begin
					inner_q <= rx_byte;
				end else if (idx == IDX_FIRST_LEN) begin
					len1_q <= rx_byte;
				end else if ((idx == FIRST_STR_OFS + {1'b0, len1_q}) && !have2_q) begin
					len2_q <= rx_byte;
					have2_q <= 1'b1;
				end
			end
		end
	end

endmodule

FILE: src/isfp_queue.sv
// two-entry queue between front end and back end
module isfp_queue import isfp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rec_t push_rec,
	output logic full,
	input  logic pop,
	output logic avail,
	output rec_t pop_rec
);

	rec_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign avail = (cnt_q != 2'd0);
	assign pop_rec = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

FILE: src/isfp_back.sv
// back end: frame verdict, rpc payload judgment and output register
module isfp_back import isfp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  avail,
	input  rec_t                  rec,
	output logic                  pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [VERDICT_W-1:0]  m_tuser
);

	logic                  vld_q;
	logic [OUT_DATA_W-1:0] data_q;
	logic [VERDICT_W-1:0]  verdict_q;

	logic [VERDICT_W-1:0] verdict;
	logic [VERDICT_W-1:0] judge;
	logic                 two;
	logic                 is_wifi;
	logic                 is_trig;
	logic [POS_W-1:0]     len;
	logic [POS_W-1:0]     fe;
	logic [POS_W:0]       se;
	logic [BYTE_W-1:0]    kind_o;
	logic [BYTE_W-1:0]    cmd_o;
	logic [BYTE_W-1:0]    len1_o;
	logic [BYTE_W-1:0]    len2_o;
	logic                 two_o;

	assign pop = avail && (!vld_q || m_tready);
	assign is_wifi = (rec.cmd == cfg.wifi_command_code);
	assign is_trig = (rec.cmd == cfg.trigger_command_code);
	assign len = {1'b0, rec.flen};
	assign fe = FIRST_STR_OFS + {1'b0, rec.len1};
	assign se = {1'b0, fe} + 10'd1 + {2'b00, rec.len2};

	// rpc payload judgment
	always_comb begin
		two = 1'b0;
		if (len < 9'd2) begin
			judge = V_RPC_BAD;
		end else if ({1'b0, rec.inner} != len - 9'd2) begin
			judge = V_RPC_BAD;
		end else if (!is_wifi && !is_trig) begin
			judge = V_RPC_OK;
		end else if (len < 9'd3) begin
			judge = V_RPC_BAD;
		end else if ((fe > len) || (is_wifi && (fe >= len))) begin
			judge = V_RPC_BAD;
		end else if (fe == len) begin
			judge = V_RPC_OK;
		end else if (!rec.have2) begin
			judge = V_RPC_BAD;
		end else if (se != {1'b0, len}) begin
			judge = V_RPC_BAD;
		end else begin
			judge = V_RPC_OK;
			two = 1'b1;
		end
	end

	always_comb begin
		kind_o = '0;
		cmd_o = '0;
		len1_o = '0;
		len2_o = '0;
		two_o = 1'b0;
		if (!rec.is_sum) begin
			verdict = rec.acc ? V_MID : V_REJECT;
		end else begin
			kind_o = rec.kind;
			if (!rec.acc) begin
				verdict = V_SUM_ERR;
			end else if (rec.kind != cfg.rpc_type_code) begin
				verdict = V_OTHER;
			end else begin
				verdict = judge;
				if (judge == V_RPC_OK) begin
					cmd_o = rec.cmd;
					len1_o = (is_wifi || is_trig) ? rec.len1 : '0;
					if (two) begin
						len2_o = rec.len2;
						two_o = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (!vld_q || m_tready) begin
			vld_q <= avail;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= {5'd0, two_o, len2_o, len1_o, cmd_o, kind_o, rec.pos, rec.acc};
			verdict_q <= verdict;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata = data_q;
	assign m_tuser = verdict_q;

endmodule

FILE: src/isfp_checker.sv
// port-level checks of the improv serial frame parser and their binding
`include "improv_serial_frame_parser_core_defines.svh"

module isfp_checker import isfp_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [VERDICT_W-1:0]  m_tuser
);

	// result holds while stalled
	`ISFP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// a refused byte is a header mismatch or a bad checksum
	`ISFP_ASSERT_NOW(a_refused_verdict, m_tvalid && !m_tdata[0], (m_tuser == V_REJECT) || (m_tuser == V_SUM_ERR))

	// no frame details before the frame ends
	`ISFP_ASSERT_NOW(a_mid_clean, m_tvalid && ((m_tuser == V_MID) || (m_tuser == V_REJECT)), m_tdata[42:10] == 33'd0)

	// second string only on a good rpc frame
	`ISFP_ASSERT_NOW(a_second_ok, m_tvalid && m_tdata[42], m_tuser == V_RPC_OK)

endmodule

bind improv_serial_frame_parser_core isfp_checker u_isfp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
